// ===== hw/rtl/pid_pkg.sv =====
package pid_pkg;

	// Fixed-point position of the gains and of every Q value
	localparam int FRAC_BITS = 16;

	// Field widths
	localparam int MeasW    = 16;
	localparam int TargetW  = 16;
	localparam int GainW    = 24;
	localparam int BandW    = 16;
	localparam int LimW     = 15;
	localparam int DriveW   = 32;
	localparam int ErrW     = MeasW + 1;
	localparam int PrevW    = 18;
	localparam int MagW     = ErrW;
	localparam int PropW    = GainW + 1 + ErrW;
	localparam int DerivW   = GainW + 1 + PrevW;
	localparam int IntSumW  = PropW + 1;
	localparam int TotW     = DerivW + 2;
	localparam int ScaleW   = 48;

	// Configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = GainW;

	localparam logic [CfgIdxW-1:0] REG_TARGET    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DEAD_BAND = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INT_LIMIT = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT = 3'd6;

	typedef logic signed [DriveW-1:0] drive_t;
	typedef logic signed [TotW-1:0]   wide_t;

	localparam logic [ScaleW-1:0] DRIVE_MAX_W = ScaleW'(32'h7FFF_FFFF);
	localparam drive_t            DRIVE_MAX   = 32'sh7FFF_FFFF;

	// Scale an integer limit into Q form, saturating at the largest drive value
	function automatic drive_t scaled_limit(input logic [LimW-1:0] lim);
		logic [ScaleW-1:0] s;
		s = {{(ScaleW-LimW){1'b0}}, lim} << FRAC_BITS;
		if (s > DRIVE_MAX_W)
			return DRIVE_MAX;
		return drive_t'(s[DriveW-1:0]);
	endfunction

	// Symmetric clamp to plus or minus a non-negative limit
	function automatic drive_t clamp_sym(input wide_t v, input drive_t lim);
		wide_t hi;
		wide_t lo;
		hi = TotW'(lim);
		lo = -hi;
		if (v > hi)
			return lim;
		if (v < lo)
			return -lim;
		return drive_t'(v[DriveW-1:0]);
	endfunction

endpackage

// ===== hw/rtl/pid_with_deadband_and_clamps.sv =====
// Path: the sample is registered in the input register at its transfer, and the single PID pass
//   fills the result register from it whenever that register is empty or being taken.
// Throughput: one item per cycle without stalls; the pass and controller state update together.
// Reset: arst_n clears all configuration registers, the previous error, the integral,
//   the held output and every valid flag asynchronously.
module pid_with_deadband_and_clamps (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic [pid_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [pid_pkg::CfgDataW-1:0]        cfg_data,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pid_pkg::MeasW-1:0]    measured_value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pid_pkg::DriveW-1:0]   drive_value,
	output logic                                held_in_band
);

	// Configuration registers
	logic signed [pid_pkg::TargetW-1:0] target_q;
	logic [pid_pkg::GainW-1:0]          gain_p_q;
	logic [pid_pkg::GainW-1:0]          gain_i_q;
	logic [pid_pkg::GainW-1:0]          gain_d_q;
	logic [pid_pkg::BandW-1:0]          band_q;
	logic [pid_pkg::LimW-1:0]           int_lim_q;
	logic [pid_pkg::LimW-1:0]           out_lim_q;

	// Input register
	logic                               valid_s1;
	logic signed [pid_pkg::MeasW-1:0]   meas_s1;

	// Controller state; drive_q doubles as the held output and the result payload
	logic signed [pid_pkg::PrevW-1:0]   prev_q;
	pid_pkg::drive_t                    integ_q;
	pid_pkg::drive_t                    drive_q;
	logic                               held_q;
	logic                               out_valid_q;

	logic                               advance;

	// Datapath signals
	logic signed [pid_pkg::ErrW-1:0]    err;
	logic [pid_pkg::MagW-1:0]           mag;
	logic                               out_band;
	logic signed [pid_pkg::PrevW-1:0]   diff;
	logic signed [pid_pkg::GainW:0]     gp_s;
	logic signed [pid_pkg::GainW:0]     gi_s;
	logic signed [pid_pkg::GainW:0]     gd_s;
	logic signed [pid_pkg::PropW-1:0]   p_term;
	logic signed [pid_pkg::PropW-1:0]   i_prod;
	logic signed [pid_pkg::DerivW-1:0]  d_term;
	logic signed [pid_pkg::IntSumW-1:0] i_raw;
	pid_pkg::drive_t                    i_lim;
	pid_pkg::drive_t                    o_lim;
	pid_pkg::drive_t                    i_new;
	pid_pkg::wide_t                     total;
	pid_pkg::drive_t                    drive_new;

	// Configuration decode; writes beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			band_q    <= '0;
			int_lim_q <= '0;
			out_lim_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pid_pkg::REG_TARGET:    target_q  <= cfg_data[pid_pkg::TargetW-1:0];
				pid_pkg::REG_GAIN_P:    gain_p_q  <= cfg_data[pid_pkg::GainW-1:0];
				pid_pkg::REG_GAIN_I:    gain_i_q  <= cfg_data[pid_pkg::GainW-1:0];
				pid_pkg::REG_GAIN_D:    gain_d_q  <= cfg_data[pid_pkg::GainW-1:0];
				pid_pkg::REG_DEAD_BAND: band_q    <= cfg_data[pid_pkg::BandW-1:0];
				pid_pkg::REG_INT_LIMIT: int_lim_q <= cfg_data[pid_pkg::LimW-1:0];
				pid_pkg::REG_OUT_LIMIT: out_lim_q <= cfg_data[pid_pkg::LimW-1:0];
				default: ;
			endcase
		end
	end

	// The pass advances whenever the result register is empty or being taken,
	// so a finished result never blocks the next sample for more than its stall.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Hold the sample until the pass takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			meas_s1 <= measured_value;
		end
	end

	// Error is exact: 17 bits cover every setpoint minus measurement
	assign err      = pid_pkg::ErrW'(target_q) - pid_pkg::ErrW'(meas_s1);
	assign mag      = err[pid_pkg::ErrW-1] ? pid_pkg::MagW'(-err) : pid_pkg::MagW'(err);
	assign out_band = mag > pid_pkg::MagW'(band_q);
	assign diff     = pid_pkg::PrevW'(err) - prev_q;

	// Gains are unsigned; widen by one zero bit for signed products
	assign gp_s   = {1'b0, gain_p_q};
	assign gi_s   = {1'b0, gain_i_q};
	assign gd_s   = {1'b0, gain_d_q};

	// Three independent multiplies, then integral clamp, sum and output clamp
	assign p_term = gp_s * err;
	assign i_prod = gi_s * err;
	assign d_term = gd_s * diff;

	assign i_raw  = pid_pkg::IntSumW'(integ_q) + pid_pkg::IntSumW'(i_prod);
	assign i_lim  = pid_pkg::scaled_limit(int_lim_q);
	assign o_lim  = pid_pkg::scaled_limit(out_lim_q);
	assign i_new  = pid_pkg::clamp_sym(pid_pkg::TotW'(i_raw), i_lim);

	assign total     = pid_pkg::TotW'(p_term) + pid_pkg::TotW'(i_new)
	                 + pid_pkg::TotW'(d_term);
	assign drive_new = pid_pkg::clamp_sym(total, o_lim);

	// State update and result register. The previous error is always replaced;
	// integral and held output move only outside the dead band.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			integ_q     <= '0;
			drive_q     <= '0;
			held_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				prev_q <= pid_pkg::PrevW'(err);
				held_q <= !out_band;
				if (out_band) begin
					integ_q <= i_new;
					drive_q <= drive_new;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_value  = drive_q;
	assign held_in_band = held_q;

endmodule

// ===== hw/rtl/pid_chk.sv =====
module pid_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [pid_pkg::DriveW-1:0]   drive_value,
	input logic                                held_in_band
);

	// Last transferred drive value; a held result must repeat it
	logic signed [pid_pkg::DriveW-1:0] last_drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_drive_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_drive_q <= drive_value;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_value)
			&& $stable(held_in_band))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted sample produced no result");

	a_held_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held_in_band |-> drive_value == last_drive_q)
		else $error("held result differs from previous drive");

endmodule

bind pid_with_deadband_and_clamps pid_chk u_pid_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.drive_value  (drive_value),
	.held_in_band (held_in_band)
);
